@@ hw/rtl/fpga_serial_config_loader_top_assert.svh @@
// Assertion macros shared by the configuration loader modules.
`ifndef FPGA_SERIAL_CONFIG_LOADER_TOP_ASSERT_SVH
`define FPGA_SERIAL_CONFIG_LOADER_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define FSC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsc assertion failed");

// Antecedent implies consequent in the next cycle.
`define FSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsc assertion failed");

`endif

@@ hw/rtl/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg
// Types and constants shared by the serial configuration loader modules.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // Action codes of an input word.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_BYTE  = 2'd2;
  localparam logic [1:0] ACT_SEG   = 2'd3;

  // Status codes reported with every result.
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_OK        = 3'd2;
  localparam logic [2:0] ST_INIT_TO   = 3'd3;
  localparam logic [2:0] ST_INIT_LOST = 3'd4;
  localparam logic [2:0] ST_DONE_TO   = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MSB_FIRST  = 3'd0;
  localparam logic [2:0] CFG_PROG_LOW   = 3'd1;
  localparam logic [2:0] CFG_INIT_POLL  = 3'd2;
  localparam logic [2:0] CFG_DONE_POLL  = 3'd3;
  localparam logic [2:0] CFG_POLL_LIMIT = 3'd4;
  localparam logic [2:0] CFG_TRAILER    = 3'd5;
  localparam logic [2:0] CFG_RESET_LOW  = 3'd6;

  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       final_segment;
    logic       init_pin;
    logic       done_pin;
  } in_item_t;

  typedef struct packed {
    logic       cclk;
    logic       din;
    logic       prog_n;
    logic       reset_n;
    logic       ready_for_byte;
    logic       accepted;
    logic [2:0] status;
  } out_item_t;

  // Classified command as it travels through the queue.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       first_bit;
    logic       final_segment;
    logic       init_pin;
    logic       done_pin;
  } cmd_t;

  typedef struct packed {
    logic        msb_first;
    logic [15:0] prog_low_ticks;
    logic [15:0] init_poll_ticks;
    logic [15:0] done_poll_ticks;
    logic [3:0]  poll_limit;
    logic [7:0]  trailer_clocks;
    logic [15:0] reset_low_ticks;
  } cfg_t;

endpackage

@@ hw/rtl/fsc_front.sv @@
// ----------------------------------------------------------------------------
// fsc_front
// Takes input words, classifies them into commands and pushes them into the
// command queue. The first serial bit of a data byte is picked here.
// ----------------------------------------------------------------------------
module fsc_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  fsc_pkg::in_item_t in_item,
  input  logic             msb_first,
  input  logic             q_full,
  output logic             push,
  output fsc_pkg::cmd_t    cmd
);
  import fsc_pkg::*;

  // The queue being full is the only reason to hold off the source.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Build the command word.
  always_comb begin
    cmd.op            = in_item.action;
    cmd.data_byte     = in_item.data_byte;
    cmd.first_bit     = msb_first ? in_item.data_byte[7] : in_item.data_byte[0];
    cmd.final_segment = in_item.final_segment;
    cmd.init_pin      = in_item.init_pin;
    cmd.done_pin      = in_item.done_pin;
  end

endmodule

@@ hw/rtl/fsc_queue.sv @@
// ----------------------------------------------------------------------------
// fsc_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module fsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fsc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output fsc_pkg::cmd_t q_cmd
);
  import fsc_pkg::*;

  `include "fpga_serial_config_loader_top_assert.svh"

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd   = entry[rd_ptr];

  // Storage, written without reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `FSC_ASSERT_NOW(a_no_push_full, clk, rst, full, !push)
  `FSC_ASSERT_NOW(a_no_pop_empty, clk, rst, !q_valid, !pop)

endmodule

@@ hw/rtl/fsc_back.sv @@
// ----------------------------------------------------------------------------
// fsc_back
// Carries out one command per cycle while not stalled: the load sequencer
// with its pin levels, poll and tick counters, and the registered result word.
// ----------------------------------------------------------------------------
module fsc_back (
  input  logic              clk,
  input  logic              rst,
  input  fsc_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  fsc_pkg::cmd_t     q_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output fsc_pkg::out_item_t out_item
);
  import fsc_pkg::*;

  `include "fpga_serial_config_loader_top_assert.svh"

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_PROG  = 3'd1;
  localparam logic [2:0] PH_INIT  = 3'd2;
  localparam logic [2:0] PH_READY = 3'd3;
  localparam logic [2:0] PH_SHIFT = 3'd4;
  localparam logic [2:0] PH_TRAIL = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;
  localparam logic [2:0] PH_RST   = 3'd7;

  logic [2:0]  phase,         phase_next;
  logic [15:0] tick_count,    tick_count_next;
  logic [3:0]  poll_count,    poll_count_next;
  logic [7:0]  shift_byte,    shift_byte_next;
  logic [2:0]  bit_index,     bit_index_next;
  logic        clock_half,    clock_half_next;
  logic [7:0]  trailer_count, trailer_count_next;
  logic        last_segment,  last_segment_next;
  logic [2:0]  status,        status_next;
  logic        cclk,          cclk_next;
  logic        din,           din_next;
  logic        prog_n,        prog_n_next;
  logic        reset_n,       reset_n_next;
  logic        acc;

  logic        poll_pin;
  logic [15:0] poll_wait;
  logic [2:0]  poll_code;
  logic [3:0]  poll_inc;
  logic [15:0] tick_dec;
  logic [2:0]  bit_nx;
  logic [7:0]  trl_inc;

  // A command leaves the queue whenever the result register can take it.
  assign pop = q_valid && (!out_valid || !out_stall);

  // Shared helpers for the poll, count and shift steps.
  always_comb begin
    poll_pin  = (phase == PH_INIT) ? q_cmd.init_pin : q_cmd.done_pin;
    poll_wait = (phase == PH_INIT) ? cfg.init_poll_ticks : cfg.done_poll_ticks;
    poll_code = (phase == PH_INIT) ? ST_INIT_TO : ST_DONE_TO;
    poll_inc  = poll_count + 4'd1;
    tick_dec  = (tick_count != 16'd0) ? tick_count - 16'd1 : 16'd0;
    bit_nx    = bit_index + 3'd1;
    trl_inc   = trailer_count + 8'd1;
  end

  // Sequencer next state.
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    poll_count_next    = poll_count;
    shift_byte_next    = shift_byte;
    bit_index_next     = bit_index;
    clock_half_next    = clock_half;
    trailer_count_next = trailer_count;
    last_segment_next  = last_segment;
    status_next        = status;
    cclk_next          = cclk;
    din_next           = din;
    prog_n_next        = prog_n;
    reset_n_next       = reset_n;
    acc                = 1'b0;

    if (q_cmd.op == ACT_START && phase == PH_IDLE) begin
      acc             = 1'b1;
      phase_next      = PH_PROG;
      status_next     = ST_BUSY;
      cclk_next       = 1'b0;
      din_next        = 1'b0;
      prog_n_next     = 1'b0;
      reset_n_next    = 1'b1;
      tick_count_next = cfg.prog_low_ticks;
      poll_count_next = 4'd0;
      last_segment_next = 1'b0;
    end else if (q_cmd.op == ACT_BYTE && phase == PH_READY) begin
      acc             = 1'b1;
      shift_byte_next = q_cmd.data_byte;
      bit_index_next  = 3'd0;
      clock_half_next = 1'b0;
      phase_next      = PH_SHIFT;
      cclk_next       = 1'b0;
      din_next        = q_cmd.first_bit;
    end else if (q_cmd.op == ACT_SEG && phase == PH_READY) begin
      acc                = 1'b1;
      last_segment_next  = q_cmd.final_segment;
      trailer_count_next = 8'd0;
      clock_half_next    = 1'b0;
      if (cfg.trailer_clocks == 8'd0) begin
        // Segment ends at once.
        if (q_cmd.final_segment) begin
          phase_next      = PH_DONE;
          tick_count_next = 16'd0;
          poll_count_next = 4'd0;
        end else begin
          phase_next = PH_READY;
        end
      end else begin
        phase_next = PH_TRAIL;
        cclk_next  = 1'b0;
      end
    end else begin
      // Any other word counts as a tick.
      acc = (q_cmd.op == ACT_TICK);
      case (phase)
        PH_PROG: begin
          tick_count_next = tick_dec;
          if (tick_dec == 16'd0) begin
            prog_n_next     = 1'b1;
            phase_next      = PH_INIT;
            poll_count_next = 4'd0;
          end
        end
        PH_INIT, PH_DONE: begin
          if (tick_count == 16'd0) begin
            if (poll_pin) begin
              if (phase == PH_INIT) begin
                phase_next = PH_READY;
              end else begin
                phase_next      = PH_RST;
                reset_n_next    = 1'b0;
                tick_count_next = cfg.reset_low_ticks;
              end
            end else if (poll_wait == 16'd0) begin
              poll_count_next = poll_inc;
              if (poll_inc >= cfg.poll_limit) begin
                phase_next  = PH_IDLE;
                status_next = poll_code;
              end
            end else begin
              tick_count_next = poll_wait;
            end
          end else begin
            tick_count_next = tick_dec;
            if (tick_dec == 16'd0) begin
              poll_count_next = poll_inc;
              if (poll_inc >= cfg.poll_limit) begin
                phase_next  = PH_IDLE;
                status_next = poll_code;
              end
            end
          end
        end
        PH_SHIFT: begin
          if (!clock_half) begin
            cclk_next       = 1'b1;
            clock_half_next = 1'b1;
            if (bit_index == 3'd7) begin
              if (!q_cmd.init_pin) begin
                phase_next  = PH_IDLE;
                status_next = ST_INIT_LOST;
              end else begin
                phase_next = PH_READY;
              end
            end
          end else begin
            bit_index_next  = bit_nx;
            clock_half_next = 1'b0;
            cclk_next       = 1'b0;
            din_next        = cfg.msb_first ? shift_byte[3'd7 - bit_nx]
                                            : shift_byte[bit_nx];
          end
        end
        PH_TRAIL: begin
          if (!clock_half) begin
            cclk_next          = 1'b1;
            clock_half_next    = 1'b1;
            trailer_count_next = trl_inc;
            if (trl_inc >= cfg.trailer_clocks) begin
              if (last_segment) begin
                phase_next      = PH_DONE;
                tick_count_next = 16'd0;
                poll_count_next = 4'd0;
              end else begin
                phase_next = PH_READY;
              end
            end
          end else begin
            cclk_next       = 1'b0;
            clock_half_next = 1'b0;
          end
        end
        PH_RST: begin
          tick_count_next = tick_dec;
          if (tick_dec == 16'd0) begin
            reset_n_next = 1'b1;
            phase_next   = PH_IDLE;
            status_next  = ST_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= 16'd0;
      poll_count    <= 4'd0;
      shift_byte    <= 8'd0;
      bit_index     <= 3'd0;
      clock_half    <= 1'b0;
      trailer_count <= 8'd0;
      last_segment  <= 1'b0;
      status        <= ST_IDLE;
      cclk          <= 1'b0;
      din           <= 1'b0;
      prog_n        <= 1'b1;
      reset_n       <= 1'b1;
    end else if (pop) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      poll_count    <= poll_count_next;
      shift_byte    <= shift_byte_next;
      bit_index     <= bit_index_next;
      clock_half    <= clock_half_next;
      trailer_count <= trailer_count_next;
      last_segment  <= last_segment_next;
      status        <= status_next;
      cclk          <= cclk_next;
      din           <= din_next;
      prog_n        <= prog_n_next;
      reset_n       <= reset_n_next;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.cclk           <= cclk_next;
      out_item.din            <= din_next;
      out_item.prog_n         <= prog_n_next;
      out_item.reset_n        <= reset_n_next;
      out_item.ready_for_byte <= (phase_next == PH_READY);
      out_item.accepted       <= acc;
      out_item.status         <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `FSC_ASSERT_NOW(a_busy_in_load, clk, rst, phase != PH_IDLE, status == ST_BUSY)
  `FSC_ASSERT_NOW(a_pins_in_shift, clk, rst, phase == PH_SHIFT,
                  prog_n && reset_n)
  `FSC_ASSERT_NEXT(a_pop_gives_word, clk, rst, pop, out_valid)

endmodule

@@ hw/rtl/fpga_serial_config_loader_top.sv @@
// A word passes through the command queue and then the result register.
// One input word and one result word per cycle are sustained when the
// output side does not stall; a two-entry queue absorbs short stalls.
// Every word is one step of the sequencer, set by its single next-state unit.
// Synchronous reset returns the sequencer to idle with prog_n and reset_n
// high, and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// fpga_serial_config_loader_top
// Passive serial configuration loader: front decode, command queue, sequencer
// back end and the configuration registers.
// ----------------------------------------------------------------------------
module fpga_serial_config_loader_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fsc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fsc_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import fsc_pkg::*;

  cfg_t cfg;
  logic push;
  logic q_full;
  logic pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t q_cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.msb_first       <= 1'b0;
      cfg.prog_low_ticks  <= 16'd1;
      cfg.init_poll_ticks <= 16'd2;
      cfg.done_poll_ticks <= 16'd10;
      cfg.poll_limit      <= 4'd10;
      cfg.trailer_clocks  <= 8'd100;
      cfg.reset_low_ticks <= 16'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MSB_FIRST:  cfg.msb_first       <= cfg_data[0];
        CFG_PROG_LOW:   cfg.prog_low_ticks  <= cfg_data;
        CFG_INIT_POLL:  cfg.init_poll_ticks <= cfg_data;
        CFG_DONE_POLL:  cfg.done_poll_ticks <= cfg_data;
        CFG_POLL_LIMIT: cfg.poll_limit      <= cfg_data[3:0];
        CFG_TRAILER:    cfg.trailer_clocks  <= cfg_data[7:0];
        CFG_RESET_LOW:  cfg.reset_low_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fsc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .msb_first(cfg.msb_first),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  fsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  fsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule
